### rtl/awc_pkg.sv
package awc_pkg;

    // Datapath widths
    localparam int D_W     = 40;   // signed wheel denominators and numerator
    localparam int NORM_W  = 39;   // magnitudes fed to the normalizer
    localparam int XY_W    = 43;   // CORDIC x and y
    localparam int Z_W     = 32;   // CORDIC angle accumulator, Q30
    localparam int NUM_W   = 36;   // divider numerator and quotient
    localparam int DEN_W   = 18;   // divider divisor
    localparam int ATAN_N  = 30;   // CORDIC steps
    localparam int NORM_N  = 6;    // normalizer steps (shift by 32, 16, 8, 4, 2, 1)
    localparam int CHAIN_N = NORM_N + ATAN_N;
    localparam int LIM_W   = 15;
    localparam int ANG_W   = 16;
    localparam int RATE_W  = 24;

    // Configuration register indexes
    localparam logic [2:0] CFG_WHEEL_BASE  = 3'd0;
    localparam logic [2:0] CFG_TRACK       = 3'd1;
    localparam logic [2:0] CFG_WHEEL_RAD   = 3'd2;
    localparam logic [2:0] CFG_RIGHT_LIMIT = 3'd3;
    localparam logic [2:0] CFG_LEFT_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_INVERT_REAR = 3'd5;

    // atan(2^-i) in Q30 radian
    localparam logic [30:0] ATAN_TAB [ATAN_N] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
        31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
        31'd1024, 31'd512, 31'd256, 31'd128, 31'd64,
        31'd32, 31'd16, 31'd8, 31'd4, 31'd2
    };

    // Per-request flags that travel beside the cell chains
    typedef struct packed {
        logic valid;
        logic low_speed;
        logic pos;
        logic sing_l;
        logic sing_r;
        logic neg_l;
        logic neg_r;
        logic dneg_l;
        logic dneg_r;
    } meta_t;

    // Front end result handed to the cell chains
    typedef struct packed {
        meta_t               meta;
        logic [NORM_W-1:0]   ad_l;
        logic [NORM_W-1:0]   ad_r;
        logic [NORM_W-1:0]   an;
        logic [NUM_W-1:0]    num_l;
        logic [NUM_W-1:0]    num_r;
        logic [DEN_W-1:0]    den;
    } front_t;

endpackage

### rtl/awc_front.sv
module awc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic signed [18:0]          fwd_speed,
    input  logic signed [20:0]          turn_rate,
    input  logic [17:0]                 wheel_base_len,
    input  logic [17:0]                 track_len,
    input  logic [17:0]                 wheel_rad,
    output awc_pkg::front_t             front
);

    // Stage 1 registers
    logic                               v1_valid_reg;
    logic signed [18:0]                 v1_reg;
    logic signed [20:0]                 w1_reg;
    logic signed [awc_pkg::D_W-1:0]     tw1_reg;
    logic signed [awc_pkg::D_W-1:0]     n21_reg;
    logic signed [awc_pkg::D_W-1:0]     tw_prod;
    logic signed [awc_pkg::D_W-1:0]     n2_prod;

    // Stage 2 registers
    logic                               v2_valid_reg;
    logic [awc_pkg::D_W-1:0]            adl2_reg;
    logic [awc_pkg::D_W-1:0]            adr2_reg;
    logic [awc_pkg::D_W-1:0]            an2_reg;
    logic [18:0]                        av2_reg;
    logic                               low2_reg;
    logic                               pos2_reg;
    logic                               negl2_reg;
    logic                               negr2_reg;
    logic                               dnegl2_reg;
    logic                               dnegr2_reg;
    logic signed [awc_pkg::D_W-1:0]     vsh;
    logic signed [awc_pkg::D_W-1:0]     dl;
    logic signed [awc_pkg::D_W-1:0]     dr;

    // Stage 3 signals
    logic [31:0]                        sl_prod;
    logic [31:0]                        sr_prod;
    logic [31:0]                        av_sh;
    logic [17:0]                        rad;
    logic [awc_pkg::D_W-1:0]            suml;
    logic [awc_pkg::D_W-1:0]            sumr;
    awc_pkg::front_t                    front_reg;

    // Products of the track and wheel base with the yaw rate
    assign tw_prod = $signed({1'b0, track_len}) * turn_rate;
    assign n2_prod = $signed({1'b0, wheel_base_len, 1'b0}) * turn_rate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
        end
        else
        begin
            v1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg  <= fwd_speed;
        w1_reg  <= turn_rate;
        tw1_reg <= tw_prod;
        n21_reg <= n2_prod;
    end

    // Wheel denominators, in units of 2^-17 metre per second
    assign vsh = {{4{v1_reg[18]}}, v1_reg, 17'b0};
    assign dl  = vsh - tw1_reg;
    assign dr  = vsh + tw1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_valid_reg <= 1'b0;
        end
        else
        begin
            v2_valid_reg <= v1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adl2_reg   <= dl[awc_pkg::D_W-1] ? 40'(-dl) : 40'(dl);
        adr2_reg   <= dr[awc_pkg::D_W-1] ? 40'(-dr) : 40'(dr);
        an2_reg    <= n21_reg[awc_pkg::D_W-1] ? 40'(-n21_reg) : 40'(n21_reg);
        av2_reg    <= v1_reg[18] ? 19'(-v1_reg) : 19'(v1_reg);
        low2_reg   <= (v1_reg[18] ? 19'(-v1_reg) : 19'(v1_reg)) < 19'd7;
        pos2_reg   <= (w1_reg == 21'sd0) ||
                      ((!w1_reg[20]) == ((!v1_reg[18]) && (v1_reg != 19'sd0)));
        negl2_reg  <= n21_reg[awc_pkg::D_W-1] != dl[awc_pkg::D_W-1];
        negr2_reg  <= n21_reg[awc_pkg::D_W-1] != dr[awc_pkg::D_W-1];
        dnegl2_reg <= dl[awc_pkg::D_W-1];
        dnegr2_reg <= dr[awc_pkg::D_W-1];
    end

    // Near-singular test: |d| * 1e6 < |v| * 2^17, reduced by 64 on both sides
    assign sl_prod = 32'(adl2_reg[17:0]) * 32'd15625;
    assign sr_prod = 32'(adr2_reg[17:0]) * 32'd15625;
    assign av_sh   = 32'({av2_reg, 11'b0});

    // Rear numerator with rounding offset, pre-divided by 512
    assign rad  = (wheel_rad == 18'd0) ? 18'd1 : wheel_rad;
    assign suml = adl2_reg + 40'({rad, 8'b0});
    assign sumr = adr2_reg + 40'({rad, 8'b0});

    // Stage 3 register handed to the cell chains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg.meta.valid     <= v2_valid_reg;
            front_reg.meta.low_speed <= low2_reg;
            front_reg.meta.pos       <= pos2_reg;
            front_reg.meta.sing_l    <= (adl2_reg[39:18] == 22'd0) && (sl_prod < av_sh);
            front_reg.meta.sing_r    <= (adr2_reg[39:18] == 22'd0) && (sr_prod < av_sh);
            front_reg.meta.neg_l     <= negl2_reg;
            front_reg.meta.neg_r     <= negr2_reg;
            front_reg.meta.dneg_l    <= dnegl2_reg;
            front_reg.meta.dneg_r    <= dnegr2_reg;
            front_reg.ad_l           <= adl2_reg[awc_pkg::NORM_W-1:0];
            front_reg.ad_r           <= adr2_reg[awc_pkg::NORM_W-1:0];
            front_reg.an             <= an2_reg[awc_pkg::NORM_W-1:0];
            front_reg.num_l          <= 36'(suml[39:9]);
            front_reg.num_r          <= 36'(sumr[39:9]);
            front_reg.den            <= rad;
        end
    end

    assign front = front_reg;

endmodule

### rtl/awc_norm_cell.sv
module awc_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                            clk,
    input  logic [awc_pkg::NORM_W-1:0]      x_in,
    input  logic [awc_pkg::NORM_W-1:0]      y_in,
    output logic [awc_pkg::NORM_W-1:0]      x_out,
    output logic [awc_pkg::NORM_W-1:0]      y_out
);

    localparam logic [awc_pkg::NORM_W-1:0] LIMIT =
        awc_pkg::NORM_W'(1) << (awc_pkg::NORM_W - 1 - SHIFT);

    logic [awc_pkg::NORM_W-1:0] x_reg;
    logic [awc_pkg::NORM_W-1:0] y_reg;
    logic [awc_pkg::NORM_W-1:0] max_xy;

    // Shift both operands up while the larger stays below 2^38
    assign max_xy = (x_in > y_in) ? x_in : y_in;

    always_ff @(posedge clk)
    begin
        if (max_xy < LIMIT)
        begin
            x_reg <= x_in << SHIFT;
            y_reg <= y_in << SHIFT;
        end
        else
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

### rtl/awc_cordic_cell.sv
module awc_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic signed [awc_pkg::XY_W-1:0]     x_in,
    input  logic signed [awc_pkg::XY_W-1:0]     y_in,
    input  logic signed [awc_pkg::Z_W-1:0]      z_in,
    output logic signed [awc_pkg::XY_W-1:0]     x_out,
    output logic signed [awc_pkg::XY_W-1:0]     y_out,
    output logic signed [awc_pkg::Z_W-1:0]      z_out
);

    localparam logic signed [awc_pkg::Z_W-1:0] ANGLE =
        $signed(awc_pkg::Z_W'(awc_pkg::ATAN_TAB[IDX]));

    logic signed [awc_pkg::XY_W-1:0] x_reg;
    logic signed [awc_pkg::XY_W-1:0] y_reg;
    logic signed [awc_pkg::Z_W-1:0]  z_reg;
    logic signed [awc_pkg::XY_W-1:0] x_sh;
    logic signed [awc_pkg::XY_W-1:0] y_sh;

    // One vectoring rotation, driving y toward zero
    assign x_sh = x_in >>> IDX;
    assign y_sh = y_in >>> IDX;

    always_ff @(posedge clk)
    begin
        if (!y_in[awc_pkg::XY_W-1])
        begin
            x_reg <= x_in + y_sh;
            y_reg <= y_in - x_sh;
            z_reg <= z_in + ANGLE;
        end
        else
        begin
            x_reg <= x_in - y_sh;
            y_reg <= y_in + x_sh;
            z_reg <= z_in - ANGLE;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

### rtl/awc_div_cell.sv
module awc_div_cell (
    input  logic                            clk,
    input  logic [awc_pkg::DEN_W-1:0]       rem_in,
    input  logic [awc_pkg::NUM_W-1:0]       num_in,
    input  logic [awc_pkg::DEN_W-1:0]       den_in,
    output logic [awc_pkg::DEN_W-1:0]       rem_out,
    output logic [awc_pkg::NUM_W-1:0]       num_out,
    output logic [awc_pkg::DEN_W-1:0]       den_out
);

    logic [awc_pkg::DEN_W-1:0] rem_reg;
    logic [awc_pkg::NUM_W-1:0] num_reg;
    logic [awc_pkg::DEN_W-1:0] den_reg;
    logic [awc_pkg::DEN_W:0]   trial;
    logic [awc_pkg::DEN_W:0]   diff;
    logic                      ge;

    // One restoring step: the quotient bit replaces the numerator bit shifted out
    assign trial = {rem_in, num_in[awc_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk)
    begin
        rem_reg <= ge ? diff[awc_pkg::DEN_W-1:0] : trial[awc_pkg::DEN_W-1:0];
        num_reg <= {num_in[awc_pkg::NUM_W-2:0], ge};
        den_reg <= den_in;
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

### rtl/ackermann_wheel_command_unit.sv
// Channel    | Ports                                      | Handshake
// -----------+--------------------------------------------+-------------------------------
// request    | fwd_speed, turn_rate                       | start high while busy low
// result     | left/right_steer_angle, rear_left/right_rate | done high for one cycle
// config     | cfg_idx, cfg_wdata                         | cfg_we high, no wait
//
// Every request yields one result after three front-end stages, a row of
// 36 cells (six normalizer cells then 30 CORDIC cells per wheel angle, 36 restoring
// divider cells per rear rate) and the output register. A request may be issued in
// every cycle; busy is always low. Reset clears the valid line and loads the register
// defaults. The receiver cannot stall, so nothing in the chain ever holds.
module ackermann_wheel_command_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [18:0]  fwd_speed,
    input  logic signed [20:0]  turn_rate,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [17:0]         cfg_wdata,
    output logic                done,
    output logic signed [15:0]  left_steer_angle,
    output logic signed [15:0]  right_steer_angle,
    output logic signed [23:0]  rear_left_rate,
    output logic signed [23:0]  rear_right_rate
);

    localparam int NW = awc_pkg::NORM_W;
    localparam int XW = awc_pkg::XY_W;
    localparam int ZW = awc_pkg::Z_W;
    localparam int MW = awc_pkg::NUM_W;
    localparam int DW = awc_pkg::DEN_W;

    // Configuration registers
    logic [17:0]                wheel_base_len_reg;
    logic [17:0]                track_len_reg;
    logic [17:0]                wheel_rad_reg;
    logic [14:0]                right_steer_limit_reg;
    logic [14:0]                left_steer_limit_reg;
    logic                       invert_rear_reg;

    awc_pkg::front_t            front;
    awc_pkg::meta_t             meta_reg [awc_pkg::CHAIN_N];
    awc_pkg::meta_t             meta_last;

    // Links between cells
    logic [NW-1:0]              nxl [awc_pkg::NORM_N+1];
    logic [NW-1:0]              nyl [awc_pkg::NORM_N+1];
    logic [NW-1:0]              nxr [awc_pkg::NORM_N+1];
    logic [NW-1:0]              nyr [awc_pkg::NORM_N+1];
    logic signed [XW-1:0]       cxl [awc_pkg::ATAN_N+1];
    logic signed [XW-1:0]       cyl [awc_pkg::ATAN_N+1];
    logic signed [ZW-1:0]       czl [awc_pkg::ATAN_N+1];
    logic signed [XW-1:0]       cxr [awc_pkg::ATAN_N+1];
    logic signed [XW-1:0]       cyr [awc_pkg::ATAN_N+1];
    logic signed [ZW-1:0]       czr [awc_pkg::ATAN_N+1];
    logic [DW-1:0]              rl  [awc_pkg::CHAIN_N+1];
    logic [MW-1:0]              ql  [awc_pkg::CHAIN_N+1];
    logic [DW-1:0]              dl  [awc_pkg::CHAIN_N+1];
    logic [DW-1:0]              rr  [awc_pkg::CHAIN_N+1];
    logic [MW-1:0]              qr  [awc_pkg::CHAIN_N+1];
    logic [DW-1:0]              dr  [awc_pkg::CHAIN_N+1];

    // Output registers
    logic                       done_reg;
    logic signed [15:0]         left_angle_reg;
    logic signed [15:0]         right_angle_reg;
    logic signed [23:0]         rear_left_reg;
    logic signed [23:0]         rear_right_reg;

    // Rounds the CORDIC angle to Q14, applies the sign and the limit.
    function automatic logic [15:0] angle_fix(input logic signed [ZW-1:0] z,
                                              input logic neg, input logic sing,
                                              input logic pos, input logic [14:0] lim);
        logic [ZW-1:0] zc;
        logic [ZW-1:0] rnd;
        logic [14:0]   mag;
        logic [15:0]   res;
        zc  = z[ZW-1] ? '0 : ZW'(z);
        rnd = zc + ZW'(32768);
        mag = (rnd[30:16] > lim) ? lim : rnd[30:16];
        if (sing)
        begin
            res = pos ? {1'b0, lim} : 16'(-{1'b0, lim});
        end
        else
        begin
            res = neg ? 16'(-{1'b0, mag}) : {1'b0, mag};
        end
        return res;
    endfunction

    // Signs and saturates a rear rate magnitude to 24 bits.
    function automatic logic [23:0] rate_fix(input logic [MW-1:0] q, input logic sgn);
        logic        big;
        logic [23:0] res;
        big = q[MW-1:23] != '0;
        if (sgn)
        begin
            res = big ? 24'h800000 : 24'(-q[23:0]);
        end
        else
        begin
            res = big ? 24'h7FFFFF : q[23:0];
        end
        return res;
    endfunction

    // Every cycle may take a request
    assign busy = 1'b0;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_len_reg    <= 18'd9372;
            track_len_reg         <= 18'd10617;
            wheel_rad_reg         <= 18'd2097;
            right_steer_limit_reg <= 15'd8192;
            left_steer_limit_reg  <= 15'd8192;
            invert_rear_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                awc_pkg::CFG_WHEEL_BASE:  wheel_base_len_reg    <= cfg_wdata;
                awc_pkg::CFG_TRACK:       track_len_reg         <= cfg_wdata;
                awc_pkg::CFG_WHEEL_RAD:   wheel_rad_reg         <= cfg_wdata;
                awc_pkg::CFG_RIGHT_LIMIT: right_steer_limit_reg <= cfg_wdata[14:0];
                awc_pkg::CFG_LEFT_LIMIT:  left_steer_limit_reg  <= cfg_wdata[14:0];
                awc_pkg::CFG_INVERT_REAR: invert_rear_reg       <= cfg_wdata[0];
                default:                  ;
            endcase
        end
    end

    // Front end: products, denominators, singular test, rear numerators
    awc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (start && !busy),
        .fwd_speed      (fwd_speed),
        .turn_rate      (turn_rate),
        .wheel_base_len (wheel_base_len_reg),
        .track_len      (track_len_reg),
        .wheel_rad      (wheel_rad_reg),
        .front          (front)
    );

    // Flags travel beside the cells and are cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < awc_pkg::CHAIN_N; i++)
            begin
                meta_reg[i] <= '0;
            end
        end
        else
        begin
            meta_reg[0] <= front.meta;
            for (int i = 1; i < awc_pkg::CHAIN_N; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign meta_last = meta_reg[awc_pkg::CHAIN_N-1];

    // Normalizer cells
    assign nxl[0] = front.ad_l;
    assign nyl[0] = front.an;
    assign nxr[0] = front.ad_r;
    assign nyr[0] = front.an;

    for (genvar k = 0; k < awc_pkg::NORM_N; k++)
    begin : g_norm
        awc_norm_cell #(.SHIFT(32 >> k)) u_norm_l (
            .clk   (clk),
            .x_in  (nxl[k]),
            .y_in  (nyl[k]),
            .x_out (nxl[k+1]),
            .y_out (nyl[k+1])
        );
        awc_norm_cell #(.SHIFT(32 >> k)) u_norm_r (
            .clk   (clk),
            .x_in  (nxr[k]),
            .y_in  (nyr[k]),
            .x_out (nxr[k+1]),
            .y_out (nyr[k+1])
        );
    end

    // CORDIC cells
    assign cxl[0] = $signed(XW'(nxl[awc_pkg::NORM_N]));
    assign cyl[0] = $signed(XW'(nyl[awc_pkg::NORM_N]));
    assign czl[0] = '0;
    assign cxr[0] = $signed(XW'(nxr[awc_pkg::NORM_N]));
    assign cyr[0] = $signed(XW'(nyr[awc_pkg::NORM_N]));
    assign czr[0] = '0;

    for (genvar k = 0; k < awc_pkg::ATAN_N; k++)
    begin : g_cordic
        awc_cordic_cell #(.IDX(k)) u_cordic_l (
            .clk   (clk),
            .x_in  (cxl[k]),
            .y_in  (cyl[k]),
            .z_in  (czl[k]),
            .x_out (cxl[k+1]),
            .y_out (cyl[k+1]),
            .z_out (czl[k+1])
        );
        awc_cordic_cell #(.IDX(k)) u_cordic_r (
            .clk   (clk),
            .x_in  (cxr[k]),
            .y_in  (cyr[k]),
            .z_in  (czr[k]),
            .x_out (cxr[k+1]),
            .y_out (cyr[k+1]),
            .z_out (czr[k+1])
        );
    end

    // Divider cells for the rear rates
    assign rl[0] = '0;
    assign ql[0] = front.num_l;
    assign dl[0] = front.den;
    assign rr[0] = '0;
    assign qr[0] = front.num_r;
    assign dr[0] = front.den;

    for (genvar k = 0; k < awc_pkg::CHAIN_N; k++)
    begin : g_div
        awc_div_cell u_div_l (
            .clk     (clk),
            .rem_in  (rl[k]),
            .num_in  (ql[k]),
            .den_in  (dl[k]),
            .rem_out (rl[k+1]),
            .num_out (ql[k+1]),
            .den_out (dl[k+1])
        );
        awc_div_cell u_div_r (
            .clk     (clk),
            .rem_in  (rr[k]),
            .num_in  (qr[k]),
            .den_in  (dr[k]),
            .rem_out (rr[k+1]),
            .num_out (qr[k+1]),
            .den_out (dr[k+1])
        );
    end

    // Final rounding, limits and saturation, or zeros at low speed, into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= meta_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_last.low_speed)
        begin
            left_angle_reg  <= '0;
            right_angle_reg <= '0;
            rear_left_reg   <= '0;
            rear_right_reg  <= '0;
        end
        else
        begin
            left_angle_reg  <= $signed(angle_fix(czl[awc_pkg::ATAN_N], meta_last.neg_l,
                                                 meta_last.sing_l, meta_last.pos,
                                                 left_steer_limit_reg));
            right_angle_reg <= $signed(angle_fix(czr[awc_pkg::ATAN_N], meta_last.neg_r,
                                                 meta_last.sing_r, meta_last.pos,
                                                 right_steer_limit_reg));
            rear_left_reg   <= $signed(rate_fix(ql[awc_pkg::CHAIN_N],
                                                meta_last.dneg_l ^ invert_rear_reg));
            rear_right_reg  <= $signed(rate_fix(qr[awc_pkg::CHAIN_N],
                                                meta_last.dneg_r ^ invert_rear_reg));
        end
    end

    assign done              = done_reg;
    assign left_steer_angle  = left_angle_reg;
    assign right_steer_angle = right_angle_reg;
    assign rear_left_rate    = rear_left_reg;
    assign rear_right_rate   = rear_right_reg;

endmodule
